// ----- src/sswm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seed segment window matcher package
// Shared widths, constants, codes and controller/datapath handshake structs.
// ----------------------------------------------------------------------------
package sswm_pkg;

    localparam int NUM_CRACKS_DEF  = 4;
    localparam int MAX_CAND_DEF    = 64;
    localparam int CRACK_SLOTS     = 4;

    localparam int ANG_W     = 15;
    localparam int THETA_W   = 14;
    localparam int CFG_W     = 14;
    localparam int CFG_IDX_W = 3;
    localparam int HIT_W     = 4;
    localparam int IDX_W     = 6;
    localparam int SCORE_W   = 32;

    localparam logic [SCORE_W-1:0] SCORE_LIMIT = 32'd2560000;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ETA_WINDOW       = 3'd0,
        CFG_CRACK_ETA_WINDOW = 3'd1,
        CFG_PHI_WINDOW       = 3'd2,
        CFG_CRACK_HALF_WIDTH = 3'd3,
        CFG_CRACK_ETA_A      = 3'd4,
        CFG_CRACK_ETA_B      = 3'd5,
        CFG_CRACK_ETA_C      = 3'd6,
        CFG_CRACK_ETA_D      = 3'd7
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SQ,
        ST_KM,
        ST_ACC,
        ST_DIV_INIT,
        ST_DIV,
        ST_UPDATE,
        ST_EMIT
    } state_t;

    // Chi-square terms, in the order the multiplier walks them.
    typedef enum logic [1:0] {
        TERM_POS_PHI,
        TERM_POS_THETA,
        TERM_DIR_PHI,
        TERM_DIR_THETA
    } term_t;

    typedef struct packed {
        logic  capture;
        logic  load_seed;
        logic  eval;
        logic  mul_sq;
        logic  mul_k;
        logic  acc;
        logic  div_init;
        logic  div_step;
        logic  update;
        logic  emit;
        term_t term;
    } cmd_t;

    typedef struct packed {
        logic is_seed;
        logic last;
        logic pass;
        logic chi_mode;
        logic div_done;
        logic out_free;
    } sts_t;

endpackage

// ----- src/sswm_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seed segment window matcher channels
// Valid/ready interfaces for the segment input and the result output.
// ----------------------------------------------------------------------------
interface sswm_in_if
    import sswm_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic                       req_type;
    logic signed [ANG_W-1:0]    pos_eta;
    logic signed [ANG_W-1:0]    pos_phi;
    logic        [THETA_W-1:0]  pos_theta;
    logic signed [ANG_W-1:0]    dir_phi;
    logic        [THETA_W-1:0]  dir_theta;
    logic                       is_drift_tube;
    logic                       is_slanted_ring;
    logic        [HIT_W-1:0]    hit_count;
    logic                       last;

    modport source (
        output valid, req_type, pos_eta, pos_phi, pos_theta, dir_phi, dir_theta,
               is_drift_tube, is_slanted_ring, hit_count, last,
        input  ready
    );
    modport sink (
        input  valid, req_type, pos_eta, pos_phi, pos_theta, dir_phi, dir_theta,
               is_drift_tube, is_slanted_ring, hit_count, last,
        output ready
    );
endinterface

interface sswm_out_if
    import sswm_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                in_window;
    logic [IDX_W-1:0]    cand_index;
    logic                is_final;
    logic                match_found;
    logic [IDX_W-1:0]    best_index;
    logic [SCORE_W-1:0]  best_score;

    modport source (
        output valid, in_window, cand_index, is_final, match_found, best_index,
               best_score,
        input  ready
    );
    modport sink (
        input  valid, in_window, cand_index, is_final, match_found, best_index,
               best_score,
        output ready
    );
endinterface

// ----- src/sswm_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seed segment window matcher controller
// Sequences window check, chi-square multiply steps, division and result.
// ----------------------------------------------------------------------------
module sswm_ctrl
    import sswm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;
    term_t  term_reg, term_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            term_reg  <= TERM_POS_PHI;
        end
        else
        begin
            state_reg <= state_next;
            term_reg  <= term_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        term_next  = term_reg;
        cmd        = '0;
        cmd.term   = term_reg;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                term_next = TERM_POS_PHI;
                if (sts.is_seed)
                begin
                    cmd.load_seed = 1'b1;
                    state_next    = sts.last ? ST_EMIT : ST_IDLE;
                end
                else
                begin
                    cmd.eval = 1'b1;
                    if (!sts.pass)
                        state_next = ST_EMIT;
                    else if (sts.chi_mode)
                        state_next = ST_SQ;
                    else
                        state_next = ST_DIV_INIT;
                end
            end
            ST_SQ:
            begin
                cmd.mul_sq = 1'b1;
                state_next = ST_KM;
            end
            ST_KM:
            begin
                cmd.mul_k  = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc = 1'b1;
                if (term_reg == TERM_DIR_THETA)
                    state_next = ST_DIV_INIT;
                else
                begin
                    term_next  = term_t'(term_reg + 2'd1);
                    state_next = ST_SQ;
                end
            end
            ST_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- src/sswm_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seed segment window matcher datapath
// Seed store, window check, shared multiplier, serial divider, best match.
// ----------------------------------------------------------------------------
module sswm_dp
    import sswm_pkg::*;
#(
    parameter int NUM_CRACKS     = NUM_CRACKS_DEF,
    parameter int MAX_CANDIDATES = MAX_CAND_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_W-1:0]          cfg_data,
    input  logic                      in_req_type,
    input  logic signed [ANG_W-1:0]   in_pos_eta,
    input  logic signed [ANG_W-1:0]   in_pos_phi,
    input  logic [THETA_W-1:0]        in_pos_theta,
    input  logic signed [ANG_W-1:0]   in_dir_phi,
    input  logic [THETA_W-1:0]        in_dir_theta,
    input  logic                      in_is_drift_tube,
    input  logic                      in_is_slanted_ring,
    input  logic [HIT_W-1:0]          in_hit_count,
    input  logic                      in_last,
    input  cmd_t                      cmd,
    output sts_t                      sts,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic                      out_in_window,
    output logic [IDX_W-1:0]          out_cand_index,
    output logic                      out_is_final,
    output logic                      out_match_found,
    output logic [IDX_W-1:0]          out_best_index,
    output logic [SCORE_W-1:0]        out_best_score
);

    localparam int CW        = $clog2(MAX_CANDIDATES + 1);
    localparam int DIV_W     = 33;
    localparam int DIV_STEPS = DIV_W;
    localparam int DCNT_W    = $clog2(DIV_STEPS);
    localparam int SQ_W      = 2 * THETA_W;
    localparam int PROD_W    = 50;
    localparam int DVS_W     = 7;
    localparam logic signed [15:0] FX_PI      = 16'sd12868;
    localparam logic signed [15:0] FX_TWO_PI  = 16'sd25736;
    localparam logic [15:0]        FX_HALF_PI = 16'd6434;

    function automatic logic signed [15:0] wrap_phi(input logic signed [15:0] d);
        logic signed [15:0] r;
        r = d;
        if (d > FX_PI)
            r = d - FX_TWO_PI;
        else if (d < -FX_PI)
            r = d + FX_TWO_PI;
        return r;
    endfunction

    function automatic logic [15:0] abs16(input logic signed [15:0] x);
        return (x < 0) ? 16'(-x) : 16'(x);
    endfunction

    // Configuration registers.
    logic [CFG_W-1:0] eta_win_reg, crack_win_reg, phi_win_reg, half_w_reg;
    logic [CFG_W-1:0] crack_reg [CRACK_SLOTS];

    function automatic logic in_crack(input logic signed [ANG_W-1:0] eta,
                                      input logic [CFG_W-1:0] half_w,
                                      input logic [CFG_W*CRACK_SLOTS-1:0] cracks);
        logic [15:0]        ae;
        logic signed [15:0] d;
        logic               hit;
        ae  = abs16(16'(eta));
        hit = 1'b0;
        for (int i = 0; i < NUM_CRACKS && i < CRACK_SLOTS; i++)
        begin
            d = $signed(ae) - $signed({2'b00, cracks[i*CFG_W +: CFG_W]});
            if (abs16(d) < {2'b00, half_w})
                hit = 1'b1;
        end
        return hit;
    endfunction

    logic [CFG_W*CRACK_SLOTS-1:0] crack_vec;
    always_comb
    begin
        for (int i = 0; i < CRACK_SLOTS; i++)
            crack_vec[i*CFG_W +: CFG_W] = crack_reg[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eta_win_reg   <= 14'd819;
            crack_win_reg <= 14'd1024;
            phi_win_reg   <= 14'd1024;
            half_w_reg    <= '0;
            for (int i = 0; i < CRACK_SLOTS; i++)
                crack_reg[i] <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_ETA_WINDOW:       eta_win_reg   <= cfg_data;
                CFG_CRACK_ETA_WINDOW: crack_win_reg <= cfg_data;
                CFG_PHI_WINDOW:       phi_win_reg   <= cfg_data;
                CFG_CRACK_HALF_WIDTH: half_w_reg    <= cfg_data;
                CFG_CRACK_ETA_A:      crack_reg[0]  <= cfg_data;
                CFG_CRACK_ETA_B:      crack_reg[1]  <= cfg_data;
                CFG_CRACK_ETA_C:      crack_reg[2]  <= cfg_data;
                CFG_CRACK_ETA_D:      crack_reg[3]  <= cfg_data;
                default:              ;
            endcase
        end
    end

    // Captured item.
    logic                     c_req_reg, c_dtc_reg, c_slc_reg, c_last_reg;
    logic signed [ANG_W-1:0]  c_pe_reg, c_pp_reg, c_dp_reg;
    logic [THETA_W-1:0]       c_pt_reg, c_dt_reg;
    logic [HIT_W-1:0]         c_hits_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            c_req_reg  <= in_req_type;
            c_pe_reg   <= in_pos_eta;
            c_pp_reg   <= in_pos_phi;
            c_pt_reg   <= in_pos_theta;
            c_dp_reg   <= in_dir_phi;
            c_dt_reg   <= in_dir_theta;
            c_dtc_reg  <= in_is_drift_tube;
            c_slc_reg  <= in_is_slanted_ring;
            c_hits_reg <= in_hit_count;
            c_last_reg <= in_last;
        end
    end

    // Seed and match state.
    logic signed [ANG_W-1:0] s_eta_reg, s_pp_reg, s_dp_reg;
    logic [THETA_W-1:0]      s_pt_reg;
    logic [2:0]              s_flags_reg;
    logic [SCORE_W-1:0]      best_score_reg, first_score_reg;
    logic [IDX_W-1:0]        best_idx_reg, first_idx_reg;
    logic [1:0]              pass_cnt_reg;
    logic [CW-1:0]           cnt_reg;

    // Window check on the captured candidate.
    logic [15:0]  deta, dphi_abs, dphig_abs, dird_abs, dpd_raw, dpd, b_abs, d_abs;
    logic         ovf, crack, pass;
    logic [13:0]  win;
    logic [HIT_W-1:0] pen;

    always_comb
    begin
        deta      = abs16(16'(c_pe_reg) - 16'(s_eta_reg));
        dphi_abs  = abs16(wrap_phi(16'(c_pp_reg) - 16'(s_pp_reg)));
        dphig_abs = abs16(wrap_phi(16'(s_pp_reg) - 16'(c_pp_reg)));
        dird_abs  = abs16(wrap_phi(16'(c_dp_reg) - 16'(s_dp_reg)));
        dpd_raw   = abs16(wrap_phi(16'(c_dp_reg) - 16'(c_pp_reg)));
        dpd       = (dpd_raw > FX_HALF_PI) ? 16'(FX_PI) - dpd_raw : dpd_raw;
        b_abs     = abs16($signed({2'b00, s_pt_reg}) - $signed({2'b00, c_pt_reg}));
        d_abs     = abs16($signed({2'b00, c_pt_reg}) - $signed({2'b00, c_dt_reg}));
        ovf       = (cnt_reg >= CW'(MAX_CANDIDATES));
        crack     = in_crack(c_pe_reg, half_w_reg, crack_vec) || s_flags_reg[2];
        win       = crack ? crack_win_reg : eta_win_reg;
        pass      = !ovf && (deta <= {2'b00, win}) && (dphi_abs <= {2'b00, phi_win_reg});
        pen       = (c_hits_reg > 4'd3) ? c_hits_reg - 4'd2 : 4'd1;
    end

    // Operands latched at evaluation.
    logic                 pass_reg, dt_mode_reg, sl_mode_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [HIT_W-1:0]     pen_reg;
    logic [THETA_W-1:0]   ta_reg, tb_reg, tc_reg, td_reg, dird_reg;

    // Shared multiplier, accumulator and restoring divider.
    logic [PROD_W-1:0]    mul_reg, acc_reg;
    logic [DIV_W-1:0]     div_reg;
    logic [DVS_W-1:0]     rem_reg, dvs_reg;
    logic [DCNT_W-1:0]    dcnt_reg;

    logic [THETA_W-1:0]   term_val;
    logic [21:0]          term_k;
    logic [DVS_W:0]       trial;
    logic                 qbit;
    logic [DVS_W-1:0]     pen9;
    logic [PROD_W:0]      chi_num;
    logic [SCORE_W-1:0]   score;

    always_comb
    begin
        case (cmd.term)
            TERM_POS_PHI:   begin term_val = ta_reg; term_k = 22'd90000;   end
            TERM_POS_THETA: begin term_val = tb_reg; term_k = 22'd4000000; end
            TERM_DIR_PHI:   begin term_val = tc_reg; term_k = 22'd10000;   end
            TERM_DIR_THETA: begin term_val = td_reg; term_k = 22'd5625;    end
            default:        begin term_val = ta_reg; term_k = 22'd90000;   end
        endcase
        trial   = {rem_reg, div_reg[DIV_W-1]};
        qbit    = (trial >= {1'b0, dvs_reg});
        pen9    = DVS_W'({3'd0, pen_reg} * 7'd9);
        // Half the denominator 9 * 2^18 * penalty, added for rounding.
        chi_num = {1'b0, acc_reg} + (PROD_W+1)'({pen9, 17'd0});
        score   = div_reg[DIV_W-1] ? '1 : div_reg[SCORE_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            ta_reg      <= dphig_abs[THETA_W-1:0];
            tb_reg      <= b_abs[THETA_W-1:0];
            tc_reg      <= dpd[THETA_W-1:0];
            td_reg      <= d_abs[THETA_W-1:0];
            dird_reg    <= dird_abs[THETA_W-1:0];
            pen_reg     <= pen;
            dt_mode_reg <= s_flags_reg[0] || c_dtc_reg;
            sl_mode_reg <= s_flags_reg[1] || c_slc_reg;
        end
        if (cmd.eval)
            acc_reg <= '0;
        else if (cmd.acc)
            acc_reg <= acc_reg + mul_reg;
        if (cmd.mul_sq)
            mul_reg <= PROD_W'(SQ_W'(term_val) * SQ_W'(term_val));
        else if (cmd.mul_k)
            mul_reg <= PROD_W'(mul_reg[SQ_W-1:0]) * PROD_W'(term_k);
        if (cmd.div_init)
        begin
            rem_reg  <= '0;
            dcnt_reg <= '0;
            if (dt_mode_reg)
            begin
                div_reg <= DIV_W'(({1'b0, dird_reg} + 15'd8) >> 4);
                dvs_reg <= DVS_W'(1);
            end
            else if (sl_mode_reg)
            begin
                div_reg <= DIV_W'(({1'b0, ta_reg} + {8'd0, pen_reg, 3'd0}) >> 4);
                dvs_reg <= DVS_W'(pen_reg);
            end
            else
            begin
                div_reg <= chi_num[PROD_W:18];
                dvs_reg <= pen9;
            end
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= qbit ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
            div_reg  <= {div_reg[DIV_W-2:0], qbit};
            dcnt_reg <= dcnt_reg + 1'b1;
        end
    end

    // Result of the list as it stands.
    logic                 fin_match;
    logic [IDX_W-1:0]     fin_idx;
    logic [SCORE_W-1:0]   fin_score;

    always_comb
    begin
        fin_match = 1'b0;
        fin_idx   = '0;
        fin_score = '0;
        if (pass_cnt_reg == 2'd1)
        begin
            fin_match = 1'b1;
            fin_idx   = first_idx_reg;
            fin_score = first_score_reg;
        end
        else if (pass_cnt_reg == 2'd2 && best_score_reg < SCORE_LIMIT)
        begin
            fin_match = 1'b1;
            fin_idx   = best_idx_reg;
            fin_score = best_score_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_eta_reg       <= '0;
            s_pp_reg        <= '0;
            s_dp_reg        <= '0;
            s_pt_reg        <= '0;
            s_flags_reg     <= '0;
            best_score_reg  <= SCORE_LIMIT;
            best_idx_reg    <= '0;
            first_idx_reg   <= '0;
            first_score_reg <= '0;
            pass_cnt_reg    <= '0;
            cnt_reg         <= '0;
            pass_reg        <= 1'b0;
            idx_reg         <= '0;
            out_valid       <= 1'b0;
        end
        else
        begin
            if (cmd.load_seed)
            begin
                s_eta_reg   <= c_pe_reg;
                s_pp_reg    <= c_pp_reg;
                s_dp_reg    <= c_dp_reg;
                s_pt_reg    <= c_pt_reg;
                s_flags_reg <= {in_crack(c_pe_reg, half_w_reg, crack_vec),
                                c_slc_reg, c_dtc_reg};
                pass_reg    <= 1'b0;
                idx_reg     <= '0;
            end
            if (cmd.eval)
            begin
                pass_reg <= pass;
                idx_reg  <= ovf ? IDX_W'(MAX_CANDIDATES - 1) : IDX_W'(cnt_reg);
                if (!ovf)
                    cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.update)
            begin
                if (pass_cnt_reg == 2'd0)
                begin
                    first_idx_reg   <= idx_reg;
                    first_score_reg <= score;
                end
                if (pass_cnt_reg != 2'd2)
                    pass_cnt_reg <= pass_cnt_reg + 2'd1;
                if (score < best_score_reg)
                begin
                    best_score_reg <= score;
                    best_idx_reg   <= idx_reg;
                end
            end
            if (cmd.load_seed || (cmd.emit && c_last_reg))
            begin
                best_score_reg  <= SCORE_LIMIT;
                best_idx_reg    <= '0;
                first_idx_reg   <= '0;
                first_score_reg <= '0;
                pass_cnt_reg    <= '0;
                cnt_reg         <= '0;
            end
            if (cmd.emit)
                out_valid <= 1'b1;
            else if (out_ready)
                out_valid <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_in_window   <= pass_reg;
            out_cand_index  <= idx_reg;
            out_is_final    <= c_last_reg;
            out_match_found <= c_last_reg && fin_match;
            out_best_index  <= c_last_reg ? fin_idx : '0;
            out_best_score  <= c_last_reg ? fin_score : '0;
        end
    end

    always_comb
    begin
        sts.is_seed  = !c_req_reg;
        sts.last     = c_last_reg;
        sts.pass     = pass;
        sts.chi_mode = !(s_flags_reg[0] || c_dtc_reg || s_flags_reg[1] || c_slc_reg);
        sts.div_done = (dcnt_reg == DCNT_W'(DIV_STEPS - 1));
        sts.out_free = !out_valid || out_ready;
    end

endmodule

// ----- src/seed_segment_window_matcher.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seed segment window matcher
// Matches a stream of candidate segments against a loaded seed segment.
// ----------------------------------------------------------------------------
// A seed item is captured and loads the reference segment; it returns a final
// item only when it also closes the list. A candidate that fails the eta or
// phi window goes straight from the window check to its result. A passing
// drift tube or slanted ring candidate then runs the divider; a passing
// chi-square candidate runs the multiplier first. The 33-step restoring
// divider forms every rounded score one quotient bit a cycle, and the single
// shared multiplier takes three steps per term (square, scale, accumulate).
// The block holds one item at a time; a finished result waits in the output
// register while the next item is accepted, and only the final hand-over of
// that next result waits for the output side. There is no clearing pass after
// reset; configuration writes take effect on the next clock edge.
// ----------------------------------------------------------------------------
module seed_segment_window_matcher
    import sswm_pkg::*;
#(
    parameter int NUM_CRACKS     = NUM_CRACKS_DEF,
    parameter int MAX_CANDIDATES = MAX_CAND_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    sswm_in_if.sink               in_ch,
    sswm_out_if.source            out_ch,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    cmd_t cmd;
    sts_t sts;

    // The controller only steps the sequence; all arithmetic and state that
    // the results depend on live in the datapath.
    sswm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sswm_dp #(
        .NUM_CRACKS     (NUM_CRACKS),
        .MAX_CANDIDATES (MAX_CANDIDATES)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_req_type        (in_ch.req_type),
        .in_pos_eta         (in_ch.pos_eta),
        .in_pos_phi         (in_ch.pos_phi),
        .in_pos_theta       (in_ch.pos_theta),
        .in_dir_phi         (in_ch.dir_phi),
        .in_dir_theta       (in_ch.dir_theta),
        .in_is_drift_tube   (in_ch.is_drift_tube),
        .in_is_slanted_ring (in_ch.is_slanted_ring),
        .in_hit_count       (in_ch.hit_count),
        .in_last            (in_ch.last),
        .cmd                (cmd),
        .sts                (sts),
        .out_valid          (out_ch.valid),
        .out_ready          (out_ch.ready),
        .out_in_window      (out_ch.in_window),
        .out_cand_index     (out_ch.cand_index),
        .out_is_final       (out_ch.is_final),
        .out_match_found    (out_ch.match_found),
        .out_best_index     (out_ch.best_index),
        .out_best_score     (out_ch.best_score)
    );

endmodule

// ----- src/sswm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seed segment window matcher checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module sswm_checker
    import sswm_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic                in_window,
    input logic [IDX_W-1:0]    cand_index,
    input logic                is_final,
    input logic                match_found,
    input logic [IDX_W-1:0]    best_index,
    input logic [SCORE_W-1:0]  best_score
);

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cand_index)
            && $stable(best_score) && $stable(is_final))
    else $error("stalled result changed");

    // The block works on one item at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("item accepted while busy");

    // Only a final result can report a match.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && match_found |-> is_final)
    else $error("match on a result that is not final");

    // Without a match the best fields read zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !match_found |-> best_score == '0 && best_index == '0)
    else $error("best fields set without a match");

endmodule

bind seed_segment_window_matcher sswm_checker u_sswm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .in_window   (out_ch.in_window),
    .cand_index  (out_ch.cand_index),
    .is_final    (out_ch.is_final),
    .match_found (out_ch.match_found),
    .best_index  (out_ch.best_index),
    .best_score  (out_ch.best_score)
);

// ----- tb/sv/sswm_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seed segment window matcher checker
// Watches the segment and result channels and the register port. It keeps
// its own model of the seed, the windows and the best-match search, and
// compares every result item field by field with the oldest expectation.
// ----------------------------------------------------------------------------
module sswm_scoreboard
    import sswm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    sswm_in_if                    seg,
    sswm_out_if                   res,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    output int                    errors,
    output int                    outstanding
);

    localparam int PI_FX      = 12868;
    localparam int TWO_PI_FX  = 25736;
    localparam int HALF_PI_FX = 6434;
    localparam int CAND_LIMIT = 64;

    typedef struct packed {
        logic                in_window;
        logic [IDX_W-1:0]    cand_index;
        logic                is_final;
        logic                match_found;
        logic [IDX_W-1:0]    best_index;
        logic [SCORE_W-1:0]  best_score;
    } match_result_t;

    match_result_t expected_q[$];

    int eta_win, crack_eta_win, phi_win, crack_half;
    int crack_pos[4];

    int  seed_eta, seed_pphi, seed_dphi, seed_pth;
    bit  seed_dt, seed_sl, seed_crack;
    longint unsigned best_sc, first_sc;
    int  best_ix, first_ix, n_pass, n_cand;

    function automatic int iabs(int v);
        return v < 0 ? -v : v;
    endfunction

    function automatic int wrap_angle(int d);
        if (d > PI_FX)
            return d - TWO_PI_FX;
        if (d < -PI_FX)
            return d + TWO_PI_FX;
        return d;
    endfunction

    function automatic longint unsigned round_div(longint unsigned num,
                                                  longint unsigned den);
        longint unsigned q;
        q = (num + den / 2) / den;
        return q > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : q;
    endfunction

    function automatic bit near_crack(int eta);
        bit hit;
        hit = 0;
        for (int i = 0; i < NUM_CRACKS_DEF; i++)
            if (iabs(iabs(eta) - crack_pos[i]) < crack_half)
                hit = 1;
        return hit;
    endfunction

    function automatic longint unsigned discriminator(int pp, int pt, int dp, int dt,
                                                      bit dtc, bit slc, int hits);
        longint unsigned pen, a, b, c, d, num;
        int dphig, dpd;
        pen = hits > 3 ? hits - 2 : 1;
        // Drift tube wins over slanted ring when both flags are set.
        if (seed_dt || dtc)
            return round_div(iabs(wrap_angle(dp - seed_dphi)), 16);
        dphig = wrap_angle(seed_pphi - pp);
        if (seed_sl || slc)
            return round_div(iabs(dphig), 16 * pen);
        dpd = iabs(wrap_angle(dp - pp));
        if (dpd > HALF_PI_FX)
            dpd = PI_FX - dpd;
        a = iabs(dphig);
        b = iabs(seed_pth - pt);
        c = dpd;
        d = iabs(pt - dt);
        num = 90000 * a * a + 4000000 * b * b + 10000 * c * c + 5625 * d * d;
        return round_div(num, 2359296 * pen);
    endfunction

    task automatic clear_search();
        best_sc  = SCORE_LIMIT;
        best_ix  = 0;
        first_ix = 0;
        first_sc = 0;
        n_pass   = 0;
        n_cand   = 0;
    endtask

    task automatic absorb_segment();
        match_result_t r;
        int pe, pp, pt, dp, dt, idx, win;
        bit dtc, slc, lst;
        longint unsigned s;
        pe  = int'(seg.pos_eta);
        pp  = int'(seg.pos_phi);
        pt  = int'(seg.pos_theta);
        dp  = int'(seg.dir_phi);
        dt  = int'(seg.dir_theta);
        dtc = seg.is_drift_tube;
        slc = seg.is_slanted_ring;
        lst = seg.last;
        r   = '0;
        if (!seg.req_type) begin
            seed_eta   = pe;
            seed_pphi  = pp;
            seed_pth   = pt;
            seed_dphi  = dp;
            seed_dt    = dtc;
            seed_sl    = slc;
            seed_crack = near_crack(pe);
            clear_search();
            if (lst) begin
                r.is_final = 1'b1;
                expected_q = {expected_q, r};
            end
            return;
        end
        if (n_cand < CAND_LIMIT) begin
            win = (near_crack(pe) || seed_crack) ? crack_eta_win : eta_win;
            idx = n_cand;
            n_cand++;
            if (iabs(pe - seed_eta) <= win && iabs(wrap_angle(pp - seed_pphi)) <= phi_win)
            begin
                s = discriminator(pp, pt, dp, dt, dtc, slc, int'(seg.hit_count));
                r.in_window = 1'b1;
                if (n_pass == 0) begin
                    first_ix = idx;
                    first_sc = s;
                end
                if (n_pass < 2)
                    n_pass++;
                if (s < best_sc) begin
                    best_sc = s;
                    best_ix = idx;
                end
            end
        end else begin
            // Overflowed candidates keep the last index and can never win.
            idx = CAND_LIMIT - 1;
        end
        r.cand_index = IDX_W'(idx);
        if (lst) begin
            r.is_final = 1'b1;
            if (n_pass == 1) begin
                r.match_found = 1'b1;
                r.best_index  = IDX_W'(first_ix);
                r.best_score  = SCORE_W'(first_sc);
            end else if (n_pass >= 2 && best_sc < SCORE_LIMIT) begin
                r.match_found = 1'b1;
                r.best_index  = IDX_W'(best_ix);
                r.best_score  = SCORE_W'(best_sc);
            end
            clear_search();
        end
        expected_q = {expected_q, r};
    endtask

    task automatic report(string what, longint unsigned got, longint unsigned want);
        $display("%0t: %s got %0d, expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    task automatic compare_result();
        match_result_t e;
        if (expected_q.size() == 0) begin
            report("unexpected result item, cand_index", res.cand_index, 0);
            return;
        end
        e = expected_q.pop_front();
        if (res.in_window !== e.in_window)
            report("in_window", res.in_window, e.in_window);
        if (res.cand_index !== e.cand_index)
            report("cand_index", res.cand_index, e.cand_index);
        if (res.is_final !== e.is_final)
            report("is_final", res.is_final, e.is_final);
        if (res.match_found !== e.match_found)
            report("match_found", res.match_found, e.match_found);
        if (res.best_index !== e.best_index)
            report("best_index", res.best_index, e.best_index);
        if (res.best_score !== e.best_score)
            report("best_score", res.best_score, e.best_score);
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            eta_win       = 819;
            crack_eta_win = 1024;
            phi_win       = 1024;
            crack_half    = 0;
            crack_pos     = '{0, 0, 0, 0};
            seed_eta      = 0;
            seed_pphi     = 0;
            seed_dphi     = 0;
            seed_pth      = 0;
            seed_dt       = 0;
            seed_sl       = 0;
            seed_crack    = 0;
            clear_search();
            expected_q.delete();
            errors      <= 0;
            outstanding <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_reg_t'(cfg_index))
                    CFG_ETA_WINDOW:       eta_win       = int'(cfg_data);
                    CFG_CRACK_ETA_WINDOW: crack_eta_win = int'(cfg_data);
                    CFG_PHI_WINDOW:       phi_win       = int'(cfg_data);
                    CFG_CRACK_HALF_WIDTH: crack_half    = int'(cfg_data);
                    CFG_CRACK_ETA_A:      crack_pos[0]  = int'(cfg_data);
                    CFG_CRACK_ETA_B:      crack_pos[1]  = int'(cfg_data);
                    CFG_CRACK_ETA_C:      crack_pos[2]  = int'(cfg_data);
                    CFG_CRACK_ETA_D:      crack_pos[3]  = int'(cfg_data);
                    default: ;
                endcase
            end
            if (res.valid && res.ready)
                compare_result();
            if (seg.valid && seg.ready)
                absorb_segment();
            outstanding <= expected_q.size();
        end
    end

    final begin
        if (expected_q.size() != 0)
            $display("%0d result items never arrived", expected_q.size());
    end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Seed segment window matcher testbench
// Drives seeds and candidate lists with random gaps and output stalls, walks
// the window and crack registers through several settings, and leaves the
// checking to the checker module beside the block.
// ----------------------------------------------------------------------------
module testbench;
    import sswm_pkg::*;

    // A passing chi-square candidate is the costliest item; the limit covers
    // every item at that cost plus the longest input gap and output stall.
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 80;
    localparam int PI_FX       = 12868;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]      cfg_data;
    int                    errors;
    int                    outstanding;
    int                    cycles = 0;
    int                    stall_phase;
    bit                    calm;

    // The seed as last sent, so that candidates can be aimed near it.
    int                    cur_eta;
    int                    cur_phi;
    int                    cur_theta;

    sswm_in_if  seg_ch ();
    sswm_out_if res_ch ();

    seed_segment_window_matcher dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (seg_ch),
        .out_ch    (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sswm_scoreboard u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .seg         (seg_ch),
        .res         (res_ch),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("seed_segment_window_matcher: mismatch");
            $finish;
        end
    end

    // The result side stalls in bursts. Each burst picks a new mood at random:
    // always ready, mostly ready, or heavily stalled.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            res_ch.ready <= 1'b0;
            stall_phase  <= 0;
        end else begin
            if (cycles % 300 == 0)
                stall_phase <= $urandom_range(0, 2);
            case (stall_phase)
                0:       res_ch.ready <= 1'b1;
                1:       res_ch.ready <= ($urandom_range(0, 99) < 75);
                default: res_ch.ready <= ($urandom_range(0, 99) < 25);
            endcase
        end
    end

    function automatic int clamp(int v, int lo, int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Mostly back-to-back or short gaps, now and then a long one.
    function automatic int gap_length();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Offers one segment item and holds it until the block takes it. Ready is
    // looked at on the falling edge, where it has settled.
    task automatic send_segment(bit cand, int pe, int pp, int pt, int dp, int dt,
                                bit dtc, bit slc, int hits, bit lst);
        int  gap;
        bit  taken;
        gap = gap_length();
        if (gap > 0) begin
            seg_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        seg_ch.valid           <= 1'b1;
        seg_ch.req_type        <= cand;
        seg_ch.pos_eta         <= ANG_W'(pe);
        seg_ch.pos_phi         <= ANG_W'(pp);
        seg_ch.pos_theta       <= THETA_W'(pt);
        seg_ch.dir_phi         <= ANG_W'(dp);
        seg_ch.dir_theta       <= THETA_W'(dt);
        seg_ch.is_drift_tube   <= dtc;
        seg_ch.is_slanted_ring <= slc;
        seg_ch.hit_count       <= HIT_W'(hits);
        seg_ch.last            <= lst;
        do begin
            @(negedge clk);
            taken = seg_ch.ready;
            @(posedge clk);
        end while (!taken);
        if (!cand) begin
            cur_eta   = pe;
            cur_phi   = pp;
            cur_theta = pt;
        end
    endtask

    // Registers only change once the block has gone quiet.
    task automatic settle();
        seg_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Holds the write enable high; write_all drops it after the last write.
    task automatic write_reg(cfg_reg_t idx, int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(value);
        @(posedge clk);
    endtask

    task automatic write_all(int ew, int cew, int pw, int hw, int ca, int cb,
                             int cc, int cd);
        write_reg(CFG_ETA_WINDOW, ew);
        write_reg(CFG_CRACK_ETA_WINDOW, cew);
        write_reg(CFG_PHI_WINDOW, pw);
        write_reg(CFG_CRACK_HALF_WIDTH, hw);
        write_reg(CFG_CRACK_ETA_A, ca);
        write_reg(CFG_CRACK_ETA_B, cb);
        write_reg(CFG_CRACK_ETA_C, cc);
        write_reg(CFG_CRACK_ETA_D, cd);
        cfg_we <= 1'b0;
    endtask

    task automatic random_seed(bit lst);
        send_segment(1'b0, $urandom_range(0, 32767) - 16384,
                     $urandom_range(0, 2 * PI_FX) - PI_FX, $urandom_range(0, PI_FX),
                     $urandom_range(0, 2 * PI_FX) - PI_FX, $urandom_range(0, PI_FX),
                     ($urandom_range(0, 3) == 0), ($urandom_range(0, 3) == 0),
                     $urandom_range(0, 15), lst);
    endtask

    // Candidates are mostly aimed at the seed so that the windows and the
    // scoring get exercised; the rest land anywhere.
    task automatic random_candidate(bit lst);
        int r, pe, pp, pt, dp, dt;
        r = $urandom_range(0, 99);
        if (r < 20) begin
            pe = cur_eta;
            pp = cur_phi;
        end else if (r < 75) begin
            pe = clamp(cur_eta + $urandom_range(0, 2400) - 1200, -16384, 16383);
            pp = cur_phi + $urandom_range(0, 2400) - 1200;
            if (pp > PI_FX)
                pp = pp - 2 * PI_FX;
            if (pp < -PI_FX)
                pp = pp + 2 * PI_FX;
        end else begin
            pe = $urandom_range(0, 32767) - 16384;
            pp = $urandom_range(0, 2 * PI_FX) - PI_FX;
        end
        if ($urandom_range(0, 1)) begin
            pt = clamp(cur_theta + $urandom_range(0, 200) - 100, 0, PI_FX);
            dp = clamp(pp + $urandom_range(0, 400) - 200, -PI_FX, PI_FX);
            dt = clamp(pt + $urandom_range(0, 400) - 200, 0, PI_FX);
        end else begin
            pt = $urandom_range(0, PI_FX);
            dp = $urandom_range(0, 2 * PI_FX) - PI_FX;
            dt = $urandom_range(0, PI_FX);
        end
        send_segment(1'b1, pe, pp, pt, dp, dt, ($urandom_range(0, 5) == 0),
                     ($urandom_range(0, 5) == 0), $urandom_range(0, 15), lst);
    endtask

    // One seed and its list. Now and then the list is cut short by a new
    // seed, closed by the seed itself, or runs past the candidate limit.
    task automatic random_list(output int sent);
        int n, r;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            random_seed(1'b1);
            sent = 1;
            return;
        end
        random_seed(1'b0);
        r = $urandom_range(0, 99);
        if (r < 3)
            n = $urandom_range(64, 70);
        else if (r < 15)
            n = $urandom_range(7, 20);
        else
            n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++)
            random_candidate(i == n - 1 && $urandom_range(0, 19) != 0);
        sent = n + 1;
    endtask

    initial begin
        int sent, phase_items;
        calm            = 1'b0;
        cur_eta         = 0;
        cur_phi         = 0;
        cur_theta       = 0;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        seg_ch.valid    = 1'b0;
        seg_ch.req_type = 1'b0;
        seg_ch.pos_eta  = '0;
        seg_ch.pos_phi  = '0;
        seg_ch.pos_theta = '0;
        seg_ch.dir_phi  = '0;
        seg_ch.dir_theta = '0;
        seg_ch.is_drift_tube   = 1'b0;
        seg_ch.is_slanted_ring = 1'b0;
        seg_ch.hit_count = '0;
        seg_ch.last     = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, under the reset register values. A candidate before
        // any seed is compared with the all-zero seed.
        send_segment(1'b1, 0, 0, 0, 0, 0, 1'b0, 1'b0, 0, 1'b1);
        // A seed that closes its own empty list.
        send_segment(1'b0, -16384, -PI_FX, PI_FX, PI_FX, PI_FX, 1'b1, 1'b1, 15, 1'b1);
        // Chi-square seed, then a lone passing candidate with a huge score
        // that still wins, since it is the only one.
        send_segment(1'b0, 100, 200, 3000, 300, 3000, 1'b0, 1'b0, 0, 1'b0);
        send_segment(1'b1, 100, 1224, 0, -PI_FX, PI_FX, 1'b0, 1'b0, 2, 1'b1);
        // Two passing candidates: strict minimum, first of equals wins.
        send_segment(1'b0, 100, 200, 3000, 300, 3000, 1'b0, 1'b0, 0, 1'b0);
        send_segment(1'b1, 919, 200, 3000, 200, 3000, 1'b0, 1'b0, 15, 1'b0);
        send_segment(1'b1, 100, 200, 3000, 200, 3000, 1'b0, 1'b0, 15, 1'b0);
        send_segment(1'b1, 920, 200, 3000, 200, 3000, 1'b0, 1'b0, 3, 1'b1);
        // Two passing candidates, both scores above the limit: no match.
        send_segment(1'b1, 100, 1200, 0, -PI_FX, PI_FX, 1'b0, 1'b0, 0, 1'b0);
        send_segment(1'b1, 100, -800, 12868, PI_FX, 0, 1'b0, 1'b0, 1, 1'b1);
        // Drift tube seed; slanted ring candidates; both flags at once.
        send_segment(1'b0, 16383, PI_FX, 0, -PI_FX, 0, 1'b1, 1'b0, 4, 1'b0);
        send_segment(1'b1, 16383, -PI_FX, 5, PI_FX, 9, 1'b0, 1'b1, 9, 1'b1);
        send_segment(1'b0, -16384, -PI_FX, 0, 0, 0, 1'b0, 1'b0, 0, 1'b0);
        send_segment(1'b1, -15565, PI_FX, 12, 7000, 1, 1'b0, 1'b1, 15, 1'b0);
        send_segment(1'b1, -16384, -PI_FX, 12, 7000, 1, 1'b1, 1'b1, 7, 1'b1);
        // A candidate after a final result, with the seed still loaded.
        send_segment(1'b1, -16000, 3000, 100, -6000, 200, 1'b0, 1'b0, 5, 1'b1);
        settle();

        // Crack setup: the first candidates lie in no crack, the second seed sits in
        // a crack and gives its own candidate the crack eta window.
        write_all(100, 2000, 16383, 300, 4096, 6144, 8192, 16383);
        send_segment(1'b0, 0, 0, 1000, 0, 1000, 1'b0, 1'b0, 6, 1'b0);
        send_segment(1'b1, 1500, 50, 1000, 10, 1000, 1'b0, 1'b0, 6, 1'b0);
        send_segment(1'b1, 1500, 50, 1000, 10, 1000, 1'b0, 1'b0, 6, 1'b1);
        send_segment(1'b0, -6200, 0, 1000, 0, 1000, 1'b0, 1'b0, 6, 1'b0);
        send_segment(1'b1, -4500, 16, 1000, 0, 1000, 1'b0, 1'b0, 6, 1'b1);
        settle();

        // Random part, over several register settings, extremes included.
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: write_all(819, 1024, 1024, 0, 0, 0, 0, 0);
                1: write_all(16383, 16383, 16383, 16383, 16383, 16383, 16383, 16383);
                2: write_all(0, 0, 0, 0, 0, 0, 0, 0);
                3: write_all(600, 1500, 800, 400, 1200, 4000, 9000, 12000);
                default: write_all($urandom_range(0, 16383), $urandom_range(0, 16383),
                                   $urandom_range(0, 2000), $urandom_range(0, 1000),
                                   $urandom_range(0, 16383), $urandom_range(0, 16383),
                                   $urandom_range(0, 16383), $urandom_range(0, 16383));
            endcase
            phase_items = 0;
            while (phase_items < 190) begin
                calm = ($urandom_range(0, 9) == 0);
                random_list(sent);
                phase_items += sent;
            end
            settle();
        end

        calm = 1'b0;
        if (errors == 0)
            $display("seed_segment_window_matcher: match");
        else
            $display("seed_segment_window_matcher: mismatch");
        $finish;
    end

endmodule
